// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/lscp_pkg.sv =====
// ---------------------------------------------------------------------------
// LRU slot cache policy package
// Shared types and constants for the controller and datapath.
// ---------------------------------------------------------------------------
package lscp_pkg;

   // key value that marks an empty slot
   localparam logic [7:0] EMPTY_KEY = 8'hFF;

   // action codes carried in req_tuser
   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_FLUSH  = 1'b1;

   // width of the result slot number
   localparam int SLOT_OUT_W = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start;   // latch key, bump clock, rewind scan
      logic flush;   // mark all slots empty
      logic scan;    // examine one slot
      logic commit;  // write slot, load result register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic match;     // current slot holds the key
      logic last;      // current slot is the final one
      logic out_busy;  // result register full and not taken
   } dp_status_type;

endpackage

// ===== rtl/lru_slot_cache_policy_core.sv =====
// ---------------------------------------------------------------------------
// LRU slot cache policy core
// Least-recently-used slot map with wrapping 8-bit access stamps.
// ---------------------------------------------------------------------------
// Channel  Direction  tdata                 tuser
// req      in         [7:0] lookup_key      [0] action (0 lookup, 1 flush)
// rsp      out        [2:0] slot_index      [0] hit
//
// A lookup is accepted, then scans the slots in order up to the hit
// (all SLOTS on a miss) and ends with an update.
// A flush is taken while the core stays idle and gives no response.
// The scan unit examines one slot per cycle; the next request is taken
// once the update has loaded the response register.
// Reset empties all slots and clears stamps and access clock.
// A stalled response holds the core in update until rsp_tready.
// ---------------------------------------------------------------------------
module lru_slot_cache_policy_core
   import lscp_pkg::*;
#(
   parameter int SLOTS = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] lookup_key
   input  logic       req_tuser,   // [0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] slot_index, [7:3] zero
   output logic       rsp_tuser    // [0] hit
);

   ctrl_cmd_type          cmd;
   dp_status_type         status;
   logic [SLOT_OUT_W-1:0] rsp_slot;

   // controller
   lscp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   lscp_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_key   (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_slot  (rsp_slot),
      .rsp_hit   (rsp_tuser)
   );

   assign rsp_tdata = {{(8 - SLOT_OUT_W){1'b0}}, rsp_slot};

endmodule

// ===== rtl/lscp_ctrl.sv =====
// ---------------------------------------------------------------------------
// LRU slot cache policy controller
// Sequences accept, slot scan and update for one request at a time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lscp_ctrl
   import lscp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_action,
   output logic          req_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_action == ACT_LOOKUP) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.match || status.last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid && req_action == ACT_LOOKUP;
            cmd.flush  = req_tvalid && req_action == ACT_FLUSH;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_UPDATE: begin
            cmd.commit = !status.out_busy;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   `ASSERT_NEXT(a_start_to_scan, clock, reset, cmd.start, state_ff == ST_SCAN, "start did not enter scan")
   `ASSERT_IMPL(a_commit_free, clock, reset, cmd.commit, !status.out_busy, "commit while result busy")
   `ASSERT_NEXT(a_match_to_update, clock, reset, state_ff == ST_SCAN && status.match, state_ff == ST_UPDATE, "match did not end scan")

endmodule

// ===== rtl/lscp_datapath.sv =====
// ---------------------------------------------------------------------------
// LRU slot cache policy datapath
// Slot key and stamp registers, access clock, scan unit and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lscp_datapath
   import lscp_pkg::*;
#(
   parameter int SLOTS = 8
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_key,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic                  rsp_hit
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [7:0]       keys_ff [SLOTS];
   logic [7:0]       stamps_ff [SLOTS];
   logic [7:0]       clock_ff;
   logic [7:0]       key_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] target_ff;
   logic [7:0]       best_age_ff;
   logic             hit_ff;

   logic                  rsp_valid_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_hit_ff;

   logic [7:0]            cur_age;
   logic                  cur_match;
   logic                  better;
   logic [IDX_W+SLOT_OUT_W-1:0] target_ext;

   // current slot under scan
   assign cur_match = keys_ff[idx_ff] == key_ff;
   assign cur_age   = 8'(clock_ff - stamps_ff[idx_ff]);
   assign better    = (idx_ff == '0) || (cur_age > best_age_ff);

   assign status.match    = cmd.scan && cur_match;
   assign status.last     = idx_ff == LAST_IDX;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // low bits of the slot number for the result
   assign target_ext = {{SLOT_OUT_W{1'b0}}, target_ff};

   // slot keys: reset and flush to empty, miss writes the new key
   always_ff @(posedge clock) begin
      if (reset || cmd.flush) begin
         for (int s = 0; s < SLOTS; s++) begin
            keys_ff[s] <= EMPTY_KEY;
         end
      end else if (cmd.commit && !hit_ff) begin
         keys_ff[target_ff] <= key_ff;
      end
   end

   // slot stamps and access clock
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            stamps_ff[s] <= 8'd0;
         end
         clock_ff <= 8'd0;
      end else begin
         if (cmd.start) begin
            clock_ff <= clock_ff + 8'd1;
         end
         if (cmd.commit) begin
            stamps_ff[target_ff] <= clock_ff;
         end
      end
   end

   // scan state
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_key;
         idx_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (cur_match) begin
            hit_ff    <= 1'b1;
            target_ff <= idx_ff;
         end else begin
            if (better) begin
               target_ff   <= idx_ff;
               best_age_ff <= cur_age;
            end
            if (!status.last) begin
               idx_ff <= idx_ff + IDX_W'(1);
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_slot_ff <= target_ext[SLOT_OUT_W-1:0];
         rsp_hit_ff  <= hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_hit   = rsp_hit_ff;

   `ASSERT_NEXT(a_clock_step, clock, reset, cmd.start, clock_ff == 8'($past(clock_ff) + 8'd1), "access clock did not advance")
   `ASSERT_NEXT(a_flush_empty, clock, reset, cmd.flush, keys_ff[0] == EMPTY_KEY, "flush left slot filled")
   `ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid_ff && rsp_hit_ff == $past(hit_ff), "result not loaded on commit")

endmodule

// ===== tb/sv/lru_slot_monitor.sv =====
// ---------------------------------------------------------------------------
// LRU slot map monitor
// Watches the request and response streams of the LRU slot cache core,
// keeps its own slot map (keys, wrapped stamps, access clock), predicts
// slot and hit for every lookup request and checks each response in order.
// ---------------------------------------------------------------------------
module lru_slot_monitor
   import lscp_pkg::*;
#(
   parameter int SLOTS = 8
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] lookup_key
   input  logic       req_tuser,   // [0] action
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [2:0] slot_index, [7:3] zero
   input  logic       rsp_tuser,   // [0] hit
   output int         mismatch_count,
   output int         pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0] slot;
      logic                  hit;
   } slot_result_type;

   // model of the slot map
   logic [7:0]      slot_key   [SLOTS];
   logic [7:0]      slot_stamp [SLOTS];
   logic [7:0]      access_clk;
   slot_result_type expected_slots [$];
   int              err_total = 0;

   // lookup: bump clock, scan for key while tracking the oldest slot
   task automatic predict_slot(input logic [7:0] key);
      int              s;
      int              victim;
      logic            found;
      logic [7:0]      age_s;
      logic [7:0]      age_v;
      slot_result_type res;
      s          = 0;
      victim     = 0;
      found      = 1'b0;
      access_clk = access_clk + 8'd1;
      while (s < SLOTS && !found) begin
         if (slot_key[s] == key) begin
            found = 1'b1;
         end else begin
            age_s = access_clk - slot_stamp[s];
            age_v = access_clk - slot_stamp[victim];
            // strictly older only, so ties keep the lowest index
            if (age_s > age_v) begin
               victim = s;
            end
            s++;
         end
      end
      if (!found) begin
         s           = victim;
         slot_key[s] = key;
      end
      slot_stamp[s] = access_clk;
      res.slot      = s[SLOT_OUT_W-1:0];
      res.hit       = found;
      expected_slots.push_back(res);
   endtask

   // sample both streams at the rising edge
   always @(posedge clock) begin : watch
      slot_result_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_key[s]   = EMPTY_KEY;
            slot_stamp[s] = 8'd0;
         end
         access_clk = 8'd0;
         expected_slots.delete();
      end else begin
         // response first: it can never belong to a request taken this edge
         if (rsp_tvalid && rsp_tready) begin
            if (expected_slots.size() == 0) begin
               if (err_total < 10) begin
                  $display("%0t: response with none expected: tdata %h hit %b",
                           $realtime, rsp_tdata, rsp_tuser);
               end
               err_total++;
            end else begin
               want = expected_slots.pop_front();
               if (rsp_tdata !== {{(8 - SLOT_OUT_W){1'b0}}, want.slot} ||
                   rsp_tuser !== want.hit) begin
                  if (err_total < 10) begin
                     $display("%0t: mismatch: slot exp %0d got tdata %h, hit exp %b got %b",
                              $realtime, want.slot, rsp_tdata, want.hit, rsp_tuser);
                  end
                  err_total++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == ACT_FLUSH) begin
               // flush empties keys only; stamps and clock are kept
               for (int s = 0; s < SLOTS; s++) begin
                  slot_key[s] = EMPTY_KEY;
               end
            end else begin
               predict_slot(req_tdata);
            end
         end
      end
      mismatch_count <= err_total;
      pending_count  <= expected_slots.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// LRU slot cache core testbench
// Drives lookup and flush requests through the core under several idle and
// stall patterns, including a long response hold-off, and reports the
// verdict from the monitor's mismatch count.
// ---------------------------------------------------------------------------
module tb
   import lscp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS           = 8;
   localparam int ITEMS_PER_PHASE = 290;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int DRAIN_CYCLES    = 16;

   typedef enum int {
      PH_FREE,
      PH_SRC_IDLE,
      PH_SINK_STALL,
      PH_BOTH,
      PH_PRESSURE
   } phase_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] lookup_key
   logic       req_tuser  = 1'b0;   // [0] action
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [2:0] slot_index, [7:3] zero
   logic       rsp_tuser;           // [0] hit

   int mismatches;
   int pending;

   // traffic shaping
   int   src_idle_pct   = 0;
   int   sink_stall_pct = 0;
   logic pressure_on    = 1'b0;
   logic hold_done      = 1'b0;
   int   hold_left      = 0;
   int   idle_cycles    = 0;

   // key pool for well-formed reuse patterns
   int pool_size = 1;
   int pool_base = 0;
   int pool_left = 0;

   lru_slot_cache_policy_core #(.SLOTS(SLOTS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lru_slot_monitor #(.SLOTS(SLOTS)) monitor (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // response side: random stalls, plus one long hold-off under pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (pressure_on && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
   end

   // watchdog on cycles with no transfer on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one request, with random idle cycles ahead of it
   task automatic send_req(input logic act, input logic [7:0] key);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic set_phase(input phase_type ph);
      case (ph)
         PH_FREE: begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
         end
         PH_SRC_IDLE: begin
            src_idle_pct   = 50;
            sink_stall_pct = 0;
         end
         PH_SINK_STALL: begin
            src_idle_pct   = 0;
            sink_stall_pct = 50;
         end
         PH_BOTH: begin
            src_idle_pct   = 19;
            sink_stall_pct = 19;
         end
         PH_PRESSURE: begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
            pressure_on    = 1'b1;
         end
         default: begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
         end
      endcase
   endtask

   // mostly lookups from a small key pool, so hits and LRU eviction both
   // show up; some flushes, empty-marker lookups and keys from the full range
   task automatic run_random(input int count);
      int r;
      int i;
      for (i = 0; i < count; i++) begin
         if (pool_left == 0) begin
            pool_size = $urandom_range(1, 12);
            pool_base = $urandom_range(0, 255);
            pool_left = $urandom_range(20, 80);
         end
         pool_left--;
         r = $urandom_range(0, 99);
         if (r < 3) begin
            send_req(ACT_FLUSH, 8'($urandom_range(0, 255)));
         end else if (r < 6) begin
            send_req(ACT_LOOKUP, EMPTY_KEY);
         end else if (r < 20) begin
            send_req(ACT_LOOKUP, 8'($urandom_range(0, 255)));
         end else begin
            send_req(ACT_LOOKUP, 8'(pool_base + $urandom_range(0, pool_size - 1)));
         end
      end
   endtask

   initial begin
      int n;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed requests
      set_phase(PH_FREE);
      send_req(ACT_LOOKUP, 8'd10);     // all ages tie: lowest slot taken
      send_req(ACT_LOOKUP, 8'd10);     // hit
      send_req(ACT_LOOKUP, EMPTY_KEY); // empty marker hits first empty slot
      send_req(ACT_LOOKUP, 8'd0);
      send_req(ACT_LOOKUP, 8'd254);
      for (n = 0; n < 6; n++) begin
         // fill remaining slots, then evict the oldest
         send_req(ACT_LOOKUP, 8'(8'h11 * (n + 1)));
      end
      send_req(ACT_LOOKUP, 8'd0);      // refresh an old slot
      send_req(ACT_FLUSH, 8'hA5);
      send_req(ACT_LOOKUP, 8'd254);    // after flush: victim by age alone
      send_req(ACT_LOOKUP, EMPTY_KEY);
      send_req(ACT_FLUSH, 8'h00);
      send_req(ACT_FLUSH, 8'hFF);      // back-to-back flush
      send_req(ACT_LOOKUP, 8'h80);
      send_req(ACT_LOOKUP, 8'h7F);

      // random requests under each traffic pattern
      set_phase(PH_FREE);
      run_random(ITEMS_PER_PHASE);
      set_phase(PH_SRC_IDLE);
      run_random(ITEMS_PER_PHASE);
      set_phase(PH_SINK_STALL);
      run_random(ITEMS_PER_PHASE);
      set_phase(PH_BOTH);
      run_random(ITEMS_PER_PHASE);
      set_phase(PH_PRESSURE);
      run_random(ITEMS_PER_PHASE);

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain outstanding responses, then let the core settle
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lscp_pkg.sv
rtl/lscp_ctrl.sv
rtl/lscp_datapath.sv
rtl/lru_slot_cache_policy_core.sv
tb/sv/lru_slot_monitor.sv
tb/sv/tb.sv
